FILE: sv/hsp_pkg.sv
`default_nettype none

package hsp_pkg;

	localparam int MAX_SECTORS_DEF  = 32;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam logic [15:0]        ONE_Q15           = 16'd32768;
	localparam logic signed [15:0] FOV_HALF          = 16'sd16384;
	localparam logic [5:0]         DEFAULT_SECTORS   = 6'd18;
	localparam logic [15:0]        DEFAULT_THRESHOLD = 16'd66;

	// Configuration register indexes.
	localparam logic CFG_NUM_SECTORS     = 1'b0;
	localparam logic CFG_STILL_THRESHOLD = 1'b1;

	// Position difference width and CORDIC working width (gain headroom included).
	localparam int DELTA_W  = 33;
	localparam int CORDIC_W = 36;
	localparam int ATAN_LEN = 24;
	localparam int STEP_W   = $clog2(ATAN_LEN);

	typedef struct packed {
		logic wr_en;
		logic clear;
		logic rd_en;
	} hsp_wt_ctrl_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051E;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2FA;
			5'd15:   r = 32'h0000517D;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A30;
			5'd19:   r = 32'h00000518;
			5'd20:   r = 32'h0000028C;
			5'd21:   r = 32'h00000146;
			5'd22:   r = 32'h000000A3;
			5'd23:   r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: sv/hsp_cordic.sv
`default_nettype none

module hsp_cordic #(
	parameter int STEPS = hsp_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic signed [hsp_pkg::DELTA_W-1:0]   x_in,
	input  wire logic signed [hsp_pkg::DELTA_W-1:0]   y_in,
	output logic                                      done,
	output logic [15:0]                               angle
);
	import hsp_pkg::*;

	logic                       run_q;
	logic                       done_q;
	logic [STEP_W-1:0]          step_q;
	logic signed [CORDIC_W-1:0] x_q, y_q;
	logic [31:0]                z_q;
	logic [15:0]                angle_q;

	logic signed [CORDIC_W-1:0] x_ext, y_ext;
	logic signed [CORDIC_W-1:0] xs, ys, x_n, y_n;
	logic [31:0]                z_n, z_round;
	logic                       last;

	assign x_ext = CORDIC_W'(x_in);
	assign y_ext = CORDIC_W'(y_in);

	assign xs   = x_q >>> step_q;
	assign ys   = y_q >>> step_q;
	assign last = (step_q == STEP_W'(STEPS - 1));

	always_comb begin
		if (!y_q[CORDIC_W-1]) begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + atan_turn(step_q);
		end else begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - atan_turn(step_q);
		end
	end

	assign z_round = z_n + 32'h00008000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (last) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// A vector in the left half-plane is first turned by a quarter turn.
	always_ff @(posedge clk) begin
		if (start) begin
			if (x_ext < 0) begin
				if (y_ext >= 0) begin
					x_q <= y_ext;
					y_q <= -x_ext;
					z_q <= 32'h40000000;
				end else begin
					x_q <= -y_ext;
					y_q <= x_ext;
					z_q <= 32'hC0000000;
				end
			end else begin
				x_q <= x_ext;
				y_q <= y_ext;
				z_q <= 32'h00000000;
			end
		end else if (run_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			if (last) begin
				angle_q <= z_round[31:16];
			end
		end
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

`default_nettype wire

FILE: sv/hsp_weights.sv
`default_nettype none

module hsp_weights #(
	parameter int DEPTH = hsp_pkg::MAX_SECTORS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire hsp_pkg::hsp_wt_ctrl_t ctrl,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire logic [15:0]           wr_data,
	input  wire logic [AW-1:0]         rd_addr,
	output logic [15:0]                rd_data
);
	import hsp_pkg::*;

	logic [15:0]      mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [15:0]      mem_rd_q;
	logic             hit_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	// An entry that was never written since the last table reset reads as 1.0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				valid_q <= '0;
			end
			if (ctrl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				hit_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = hit_q ? mem_rd_q : ONE_Q15;

endmodule

`default_nettype wire

FILE: sv/heading_sector_penalty.sv
// Heading sector penalty scorer.
//
// Input channel (in_valid / in_stall): an item with mode 0 writes one sector
// weight if its index is below the sector count and produces no result; the
// block is ready again at once. An item with mode 1 scores a trajectory and
// produces exactly one result on the output channel (out_valid / out_stall).
// A score item steps through S_ABS, S_MT, S_MX, S_MY and S_CMP, waits in
// S_CORD for the CORDIC that resolves one angle bit per cycle, then steps
// through S_SECT, S_RD and S_FIN to the output register; S_RD is skipped
// when the heading is out of view. Scores with a still or zero displacement
// skip S_CORD, items without poses go from acceptance straight to S_SECT,
// and scores before any weight has arrived go straight to S_FIN. The next
// item is taken once a score has reached the output register. in_stall is
// high while a score item is in work, so one item is scored at a time; a
// write item is taken even while a result waits.
// When the receiver stalls, the result is held in the output register and
// a finished score waits until that register is free.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
// ready and must only be written while the block is idle.
// Reset makes every sector weight 1.0, clears the weights-received flag and
// loads a count of 18 sectors and still_threshold 66; no clearing pass is needed.
`default_nettype none

module heading_sector_penalty #(
	parameter int MAX_SECTORS  = hsp_pkg::MAX_SECTORS_DEF,
	parameter int CORDIC_STEPS = hsp_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               mode,
	input  wire logic               message_start,
	input  wire logic [4:0]         weight_index,
	input  wire logic [15:0]        weight_value,
	input  wire logic               has_poses,
	input  wire logic signed [31:0] start_x,
	input  wire logic signed [31:0] start_y,
	input  wire logic signed [31:0] end_x,
	input  wire logic signed [31:0] end_y,
	input  wire logic signed [15:0] end_yaw,

	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [15:0]             penalty,
	output logic [4:0]              sector,
	output logic                    out_of_view,
	output logic                    neutral,

	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_data
);
	import hsp_pkg::*;

	localparam int AW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ABS  = 4'd1;
	localparam logic [3:0] S_MT   = 4'd2;
	localparam logic [3:0] S_MX   = 4'd3;
	localparam logic [3:0] S_MY   = 4'd4;
	localparam logic [3:0] S_CMP  = 4'd5;
	localparam logic [3:0] S_CORD = 4'd6;
	localparam logic [3:0] S_SECT = 4'd7;
	localparam logic [3:0] S_RD   = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic [3:0]  state_q;
	logic [5:0]  n_sectors_q;
	logic [15:0] still_threshold_q;
	logic        weights_received_q;

	logic signed [DELTA_W-1:0] dx_q, dy_q;
	logic [DELTA_W-1:0]        ax_q, ay_q;
	logic                      zero_q, small_q;
	logic [31:0]               thr_sq_q;
	logic [32:0]               acc_q;
	logic signed [15:0]        yaw_q;
	logic signed [15:0]        heading_q;
	logic [5:0]                idx_q;

	logic [15:0] res_pen_q;
	logic [4:0]  res_sector_q;
	logic        res_oov_q, res_neutral_q, res_use_w_q;

	logic        out_valid_q;
	logic [15:0] penalty_q;
	logic [4:0]  sector_q;
	logic        out_of_view_q, neutral_q;

	logic        in_accept;
	logic        out_free;
	logic [5:0]  n_raw, n_eff;
	logic [15:0] mul_a, mul_b;
	logic [31:0] prod;
	logic [15:0] hoff;
	logic        heading_oov;
	logic [6:0]  idx_wide;
	logic [5:0]  idx_clamped;
	logic        still;
	logic [15:0] wr_value;
	logic [15:0] fin_pen;

	hsp_wt_ctrl_t wt_ctrl;
	logic [15:0]  wt_rdata;
	logic         cord_start, cord_done;
	logic [15:0]  cord_angle;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// A zero count means the default, and the count never exceeds the table.
	assign n_raw = (n_sectors_q == 6'd0) ? DEFAULT_SECTORS : n_sectors_q;
	assign n_eff = ({3'b000, n_raw} > 9'(MAX_SECTORS)) ? 6'(MAX_SECTORS) : n_raw;

	// The single multiplier serves the threshold square, both distance
	// squares and the sector scaling in turn.
	always_comb begin
		case (state_q)
			S_MT: begin
				mul_a = still_threshold_q;
				mul_b = still_threshold_q;
			end
			S_MX: begin
				mul_a = ax_q[15:0];
				mul_b = ax_q[15:0];
			end
			S_MY: begin
				mul_a = ay_q[15:0];
				mul_b = ay_q[15:0];
			end
			S_SECT: begin
				mul_a = hoff;
				mul_b = {10'd0, n_eff};
			end
			default: begin
				mul_a = 16'd0;
				mul_b = 16'd0;
			end
		endcase
	end

	assign prod = 32'(mul_a) * 32'(mul_b);

	assign hoff        = 16'(heading_q + FOV_HALF);
	assign heading_oov = (heading_q < -FOV_HALF) || (heading_q > FOV_HALF);
	assign idx_wide    = prod[21:15];
	assign idx_clamped = (idx_wide >= {1'b0, n_eff}) ? (n_eff - 6'd1) : idx_wide[5:0];

	// The squares are only exact when both magnitudes are below the threshold.
	assign still = small_q && (acc_q < {1'b0, thr_sq_q});

	assign wr_value = (weight_value > ONE_Q15) ? ONE_Q15 : weight_value;

	assign wt_ctrl.wr_en = in_accept && !mode && ({1'b0, weight_index} < n_eff);
	assign wt_ctrl.clear = in_accept && !mode && message_start;
	assign wt_ctrl.rd_en = (state_q == S_RD);

	assign cord_start = (state_q == S_CMP) && !still && !zero_q;

	assign fin_pen = res_use_w_q ? (ONE_Q15 - wt_rdata) : res_pen_q;

	hsp_weights #(
		.DEPTH (MAX_SECTORS),
		.AW    (AW)
	) u_weights (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (wt_ctrl),
		.wr_addr (AW'(weight_index)),
		.wr_data (wr_value),
		.rd_addr (AW'(idx_q)),
		.rd_data (wt_rdata)
	);

	hsp_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.x_in   (dx_q),
		.y_in   (dy_q),
		.done   (cord_done),
		.angle  (cord_angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_sectors_q       <= DEFAULT_SECTORS;
			still_threshold_q <= DEFAULT_THRESHOLD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NUM_SECTORS:     n_sectors_q       <= cfg_data[5:0];
				CFG_STILL_THRESHOLD: still_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= S_IDLE;
			weights_received_q <= 1'b0;
			out_valid_q        <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (!mode) begin
							weights_received_q <= 1'b1;
						end else if (!weights_received_q) begin
							state_q <= S_FIN;
						end else if (!has_poses) begin
							state_q <= S_SECT;
						end else begin
							state_q <= S_ABS;
						end
					end
				end
				S_ABS:  state_q <= S_MT;
				S_MT:   state_q <= S_MX;
				S_MX:   state_q <= S_MY;
				S_MY:   state_q <= S_CMP;
				S_CMP:  state_q <= cord_start ? S_CORD : S_SECT;
				S_CORD: begin
					if (cord_done) begin
						state_q <= S_SECT;
					end
				end
				S_SECT: state_q <= heading_oov ? S_FIN : S_RD;
				S_RD:   state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				dx_q  <= DELTA_W'(end_x) - DELTA_W'(start_x);
				dy_q  <= DELTA_W'(end_y) - DELTA_W'(start_y);
				yaw_q <= end_yaw;
				heading_q     <= 16'sd0;
				res_pen_q     <= 16'd0;
				res_sector_q  <= 5'd0;
				res_oov_q     <= 1'b0;
				res_neutral_q <= 1'b1;
				res_use_w_q   <= 1'b0;
			end
			S_ABS: begin
				ax_q   <= dx_q[DELTA_W-1] ? DELTA_W'(-dx_q) : DELTA_W'(dx_q);
				ay_q   <= dy_q[DELTA_W-1] ? DELTA_W'(-dy_q) : DELTA_W'(dy_q);
				zero_q <= (dx_q == '0) && (dy_q == '0);
			end
			S_MT: begin
				thr_sq_q <= prod;
				small_q  <= (ax_q < DELTA_W'(still_threshold_q)) &&
				            (ay_q < DELTA_W'(still_threshold_q));
			end
			S_MX: acc_q <= {1'b0, prod};
			S_MY: acc_q <= acc_q + {1'b0, prod};
			S_CMP: begin
				if (still) begin
					heading_q <= yaw_q;
				end
			end
			S_CORD: begin
				if (cord_done) begin
					heading_q <= cord_angle;
				end
			end
			S_SECT: begin
				idx_q         <= idx_clamped;
				res_neutral_q <= 1'b0;
				res_pen_q     <= ONE_Q15;
				res_sector_q  <= 5'd0;
				res_oov_q     <= heading_oov;
			end
			S_RD: begin
				res_sector_q <= idx_q[4:0];
				res_use_w_q  <= 1'b1;
			end
			S_FIN: begin
				if (out_free) begin
					penalty_q     <= fin_pen;
					sector_q      <= res_sector_q;
					out_of_view_q <= res_oov_q;
					neutral_q     <= res_neutral_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign penalty     = penalty_q;
	assign sector      = sector_q;
	assign out_of_view = out_of_view_q;
	assign neutral     = neutral_q;

`ifndef SYNTHESIS
	a_penalty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> penalty <= ONE_Q15)
		else $error("penalty above 1.0");

	a_neutral_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && neutral |-> penalty == 16'd0 && sector == 5'd0 && !out_of_view)
		else $error("neutral item carries a nonzero result");

	a_oov_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_view |-> penalty == ONE_Q15 && sector == 5'd0 && !neutral)
		else $error("out of view item without full penalty");

	a_cordic_owned: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> state_q == S_CORD)
		else $error("arctangent finished while the sequencer was not waiting");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && out_free |=> out_valid && state_q == S_IDLE)
		else $error("finished score was not moved to the output register");
`endif

endmodule

`default_nettype wire
